/* rtl/mvs_pkg.sv */
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared types and constants of the majority-vote flow sketch.
// ----------------------------------------------------------------------------
package mvs_pkg;

    localparam int ROWS     = 4;     // rows of the sketch, 1 to 4
    localparam int COLUMNS  = 1024;  // buckets per row, a power of two
    localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam int ADDR_W   = 32;
    localparam int KEY_W    = 2 * ADDR_W;
    localparam int CNT_W    = 32;
    localparam int IDX_W    = 10;
    localparam int IDX_CNT  = 4;     // index fields carried by every input beat
    localparam int IDX_LSB  = KEY_W;
    localparam int S_TDATA_W = ((KEY_W + IDX_CNT * IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = CNT_W;

    // Commands carried in tuser.
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] vote;
    } bucket_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch the accepted input beat
        logic rd_en;     // read the addressed bucket of every row
        logic upd_wr;    // write back the voted buckets
        logic est_en;    // register the per-row estimates
        logic out_load;  // load the minimum into the output register
        logic clr_wr;    // clear one column of every row
    } mvs_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic query;     // the captured beat is a query
        logic clr_last;  // the clear pass is at its last column
    } mvs_status_t;

    // Bucket column of a hashed index; COLUMNS is a power of two, so the
    // modulo is a plain truncation or zero extension.
    function automatic logic [COL_W-1:0] col_of(input logic [IDX_W-1:0] idx);
        return COL_W'(idx);
    endfunction

endpackage

/* rtl/mvs_ctrl.sv */
// ----------------------------------------------------------------------------
// mvs_ctrl
// Sequencer of the sketch: clear pass, read, vote or estimate, and output.
// ----------------------------------------------------------------------------
module mvs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  mvs_pkg::mvs_status_t status,
    output mvs_pkg::mvs_cmd_t    cmd
);
    import mvs_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_MIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (status.query)
                begin
                    cmd.est_en = 1'b1;
                    state_next = S_MIN;
                end
                else
                begin
                    cmd.upd_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> cmd.rd_en)
        else $error("accepted beat not followed by a bucket read");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten while a result waits");

    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_wr |-> (!status.query && !cmd.clr_wr))
        else $error("bucket write for a query or during the clear pass");

endmodule

/* rtl/mvs_datapath.sv */
// ----------------------------------------------------------------------------
// mvs_datapath
// Per-row bucket memories, majority-vote update and minimum estimate.
// ----------------------------------------------------------------------------
module mvs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mvs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic [mvs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  mvs_pkg::mvs_cmd_t             cmd,
    output mvs_pkg::mvs_status_t          status
);
    import mvs_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic             query_reg;
    logic [COL_W-1:0] col_reg [ROWS];
    logic [COL_W-1:0] clr_cnt_reg;
    logic [COL_W-1:0] clr_cnt_next;
    bucket_t          rd_reg  [ROWS];
    bucket_t          wr_bkt  [ROWS];
    logic [CNT_W-1:0] est_reg [ROWS];
    logic [CNT_W-1:0] est_next [ROWS];
    logic [CNT_W-1:0] best;
    logic [CNT_W-1:0] out_reg;

    // Capture of the accepted beat; src_addr is the upper half of the key.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg   <= {s_axis_tdata[ADDR_W-1:0], s_axis_tdata[KEY_W-1:ADDR_W]};
            query_reg <= (s_axis_tuser == CMD_QUERY);
            for (int r = 0; r < ROWS; r++)
            begin
                col_reg[r] <= col_of(s_axis_tdata[IDX_LSB + r * IDX_W +: IDX_W]);
            end
        end
    end

    assign clr_cnt_next = clr_cnt_reg + COL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign status.query    = query_reg;
    assign status.clr_last = (clr_cnt_reg == COL_W'(COLUMNS - 1));

    for (genvar g = 0; g < ROWS; g++)
    begin : g_row
        bucket_t mem [COLUMNS];

        always_ff @(posedge clk)
        begin
            if (cmd.clr_wr)
            begin
                mem[clr_cnt_reg] <= '0;
            end
            else if (cmd.upd_wr)
            begin
                mem[col_reg[g]] <= wr_bkt[g];
            end
            if (cmd.rd_en)
            begin
                rd_reg[g] <= mem[col_reg[g]];
            end
        end
    end

    // Vote and estimate of each row on the registered bucket.
    always_comb
    begin
        logic             hit;
        logic [CNT_W-1:0] v_dec;
        logic [CNT_W-1:0] sum;
        for (int r = 0; r < ROWS; r++)
        begin
            hit   = (rd_reg[r].key == key_reg);
            v_dec = rd_reg[r].vote - CNT_W'(1);
            wr_bkt[r].total = rd_reg[r].total + CNT_W'(1);
            wr_bkt[r].key   = rd_reg[r].key;
            wr_bkt[r].vote  = v_dec;
            priority if (rd_reg[r].key == '0)
            begin
                wr_bkt[r].key  = key_reg;
                wr_bkt[r].vote = CNT_W'(1);
            end
            else if (hit)
            begin
                wr_bkt[r].vote = rd_reg[r].vote + CNT_W'(1);
            end
            else if (v_dec[CNT_W-1])
            begin
                wr_bkt[r].key  = key_reg;
                wr_bkt[r].vote = CNT_W'(0) - v_dec;
            end
            sum = hit ? (rd_reg[r].total + rd_reg[r].vote)
                      : (rd_reg[r].total - rd_reg[r].vote);
            est_next[r] = sum >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.est_en)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                est_reg[r] <= est_next[r];
            end
        end
    end

    always_comb
    begin
        best = est_reg[0];
        for (int r = 1; r < ROWS; r++)
        begin
            if (est_reg[r] < best)
            begin
                best = est_reg[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= best;
        end
    end

    assign m_axis_tdata = out_reg;

endmodule

/* rtl/majority_vote_sketch_unit.sv */
// ----------------------------------------------------------------------------
// majority_vote_sketch_unit
// Majority-vote flow sketch for heavy flow detection: updates vote a key into
// one bucket of every row, queries return the minimum per-row estimate.
// ----------------------------------------------------------------------------
// Sequence: an update is captured in S_IDLE, read in S_RD, then voted and
// written back in S_CALC; a query is captured and read the same way, has its
// per-row estimates registered in S_CALC, and has their minimum loaded into
// the output register in S_MIN, which waits while a result is still held there.
// A new beat is taken only in S_IDLE, so each beat is through these steps around
// each row's bucket memory before the block takes the next one.
// Reset: asynchronous, active low; afterwards a clearing pass over all COLUMNS
// columns zeroes all buckets while s_axis_tready stays low.
// ----------------------------------------------------------------------------
module majority_vote_sketch_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0 up: src_addr[31:0], dst_addr[31:0], row0_index[9:0],
    // row1_index[9:0], row2_index[9:0], row3_index[9:0].
    input  logic [mvs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0 up: command (0 = update, 1 = query).
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0 up: estimated_count[31:0].
    output logic [mvs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import mvs_pkg::*;

    // The controller sequences each beat; the datapath holds the memories.
    mvs_cmd_t    cmd;
    mvs_status_t status;

    mvs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // The output register in the datapath lets a finished estimate wait
    // for the sink while the next beat is already being worked on.
    mvs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the majority-vote flow sketch. Update and query
// beats go in on the slave stream. A bucket-level model of the sketch inside
// the bench predicts every query's estimated count. The master stream's
// beats are compared in order against those predictions. A short table of
// hand-checked beats comes first, then random flow traffic with idle cycles
// and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvs_pkg::*;

    localparam int RANDOM_BEATS = 1800;
    localparam int FLOWS        = 12;    // size of the recurring flow pool
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;    // settling time after the last result

    // One input beat as the sketch sees it; idx[r] is the column for row r.
    typedef struct packed {
        logic                            cmd;
        logic [ADDR_W-1:0]               src;
        logic [ADDR_W-1:0]               dst;
        logic [IDX_CNT-1:0][IDX_W-1:0]   idx;
    } flow_beat_t;

    // One row of the directed table. When chk is set, cnt is the count that
    // the query must return, worked out by hand. Otherwise the bench model
    // supplies it.
    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [IDX_W-1:0]  i0;
        logic [IDX_W-1:0]  i1;
        logic [IDX_W-1:0]  i2;
        logic [IDX_W-1:0]  i3;
        logic              chk;
        logic [CNT_W-1:0]  cnt;
    } dir_row_t;

    // Flow keys used below:
    //   A = FFFFFFFF:00000000, B = 00000000:FFFFFFFF,
    //   C = 12345678:9ABCDEF0, Z = all zero (counts as empty).
    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Queries right after the clearing pass: every bucket is empty.
        '{CMD_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b1, 32'd0},
        '{CMD_QUERY,  32'h0000_0000, 32'h0000_0000, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
          1'b1, 32'd0},
        // A takes the empty column 0 and then votes for itself.
        '{CMD_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b0, 32'd0},
        '{CMD_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b0, 32'd0},
        '{CMD_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b1, 32'd2},
        // B votes against A: total 3, vote 1, A stays the candidate.
        '{CMD_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b0, 32'd0},
        '{CMD_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b1, 32'd2},
        '{CMD_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b1, 32'd1},
        // The vote reaches zero, then goes negative and B takes over with vote 1.
        '{CMD_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b0, 32'd0},
        '{CMD_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b0, 32'd0},
        '{CMD_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b1, 32'd3},
        '{CMD_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 10'd0,    10'd0,   10'd0,   10'd0,
          1'b1, 32'd2},
        // An all-zero key is stored, but the bucket still looks empty to C.
        '{CMD_UPDATE, 32'h0000_0000, 32'h0000_0000, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
          1'b0, 32'd0},
        '{CMD_UPDATE, 32'h1234_5678, 32'h9ABC_DEF0, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
          1'b0, 32'd0},
        '{CMD_QUERY,  32'h1234_5678, 32'h9ABC_DEF0, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
          1'b1, 32'd1},
        '{CMD_QUERY,  32'h0000_0000, 32'h0000_0000, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
          1'b1, 32'd0},
        // Different columns per row, so the minimum comes from the rows.
        '{CMD_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 10'd0,    10'd1023, 10'd512, 10'd1,
          1'b0, 32'd0},
        '{CMD_QUERY,  32'hFFFF_FFFF, 32'h0000_0000, 10'd0,    10'd1023, 10'd512, 10'd1,
          1'b0, 32'd0},
        '{CMD_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
          1'b0, 32'd0},
        '{CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
          1'b0, 32'd0},
        '{CMD_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 10'd0,   10'd512, 10'd1,
          1'b0, 32'd0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // Fields from bit 0 up: src_addr[31:0], dst_addr[31:0], row0_index[9:0],
    // row1_index[9:0], row2_index[9:0], row3_index[9:0].
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // Fields from bit 0 up: command (0 = update, 1 = query).
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // Fields from bit 0 up: estimated_count[31:0].
    logic [M_TDATA_W-1:0] m_axis_tdata;

    majority_vote_sketch_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The bench's own copy of the bucket store. The bit type starts at zero,
    // which matches the store after the clearing pass.
    bit [KEY_W-1:0] cand_key   [ROWS][COLUMNS];
    bit [CNT_W-1:0] flow_total [ROWS][COLUMNS];
    bit [CNT_W-1:0] flow_vote  [ROWS][COLUMNS];

    // Counts that the master stream still owes, oldest first.
    logic [CNT_W-1:0] pending_counts [$];
    int               mismatch_cnt = 0;

    // Traffic shaping shared between the stimulus and the receiver.
    bit no_idle    = 1'b0;   // both sides run without idle cycles
    bit hold_start = 1'b0;   // asks the receiver for one long hold-off

    // Recurring flows: fixed key and fixed columns, as a real hash would give.
    logic [ADDR_W-1:0]             pool_src [FLOWS];
    logic [ADDR_W-1:0]             pool_dst [FLOWS];
    logic [IDX_CNT-1:0][IDX_W-1:0] pool_idx [FLOWS];

    // Applies one beat to the bench store. An update runs the majority vote
    // in every row. A query returns the smallest per-row count estimate.
    function automatic logic [CNT_W-1:0] vote_or_estimate(input flow_beat_t b);
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] v;
        logic [CNT_W-1:0] est;
        logic [CNT_W-1:0] lowest;
        int               col;
        key    = {b.src, b.dst};
        lowest = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            col = int'(b.idx[r]) % COLUMNS;
            if (b.cmd == CMD_UPDATE)
            begin
                flow_total[r][col] += 1;
                if (cand_key[r][col] == '0)
                begin
                    cand_key[r][col]  = key;
                    flow_vote[r][col] = 1;
                end
                else if (cand_key[r][col] == key)
                begin
                    flow_vote[r][col] += 1;
                end
                else
                begin
                    // A losing vote below zero hands the bucket to the new key.
                    v = flow_vote[r][col] - 1;
                    if (v[CNT_W-1])
                    begin
                        cand_key[r][col] = key;
                        v = -v;
                    end
                    flow_vote[r][col] = v;
                end
            end
            else
            begin
                if (cand_key[r][col] == key)
                    est = (flow_total[r][col] + flow_vote[r][col]) >> 1;
                else
                    est = (flow_total[r][col] - flow_vote[r][col]) >> 1;
                if (r == 0 || est < lowest)
                    lowest = est;
            end
        end
        return lowest;
    endfunction

    // Offers one beat, with a random gap before it, and records the expected
    // count once the beat is taken. A beat that follows straight on keeps
    // tvalid high, so tvalid is never lowered and raised in the same step.
    task automatic send_beat(input flow_beat_t b, input bit fixed, input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] est;
        while (!no_idle && $urandom_range(0, 99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({b.idx, b.dst, b.src});
        s_axis_tuser  <= b.cmd;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        est = vote_or_estimate(b);
        if (b.cmd == CMD_QUERY)
            pending_counts.push_back(fixed ? cnt : est);
    endtask

    // Receiver: random ready, a no-idle stretch, and one long hold-off that
    // lets the block fill up and stall its input.
    initial
    begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (no_idle)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 26);
        end
    end

    // Every result beat is matched against the oldest outstanding count.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %0d",
                         $time, m_axis_tdata);
                mismatch_cnt++;
            end
            else if (m_axis_tdata !== pending_counts[0])
            begin
                $display("%0t: estimated_count mismatch, expected %0d, got %0d",
                         $time, pending_counts[0], m_axis_tdata);
                mismatch_cnt++;
                void'(pending_counts.pop_front());
            end
            else
                void'(pending_counts.pop_front());
        end
    end

    // Stimulus and end of test.
    initial
    begin
        flow_beat_t b;
        dir_row_t   row;
        int         flow;
        int         pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_UPDATE;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The block holds tready low during its clearing pass, so the first
        // beat simply waits for the handshake.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row   = DIRECTED[i];
            b.cmd = row.cmd;
            b.src = row.src;
            b.dst = row.dst;
            b.idx = {row.i3, row.i2, row.i1, row.i0};
            send_beat(b, row.chk, row.cnt);
        end

        // Half the flows share a few columns so that buckets are contested.
        // The rest spread over the whole row.
        for (int f = 0; f < FLOWS; f++)
        begin
            pool_src[f] = $urandom;
            pool_dst[f] = $urandom;
            for (int r = 0; r < IDX_CNT; r++)
                pool_idx[f][r] = (f < FLOWS / 2) ? IDX_W'($urandom_range(0, 7))
                                                 : IDX_W'($urandom_range(0, 1023));
        end

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == 400)
                hold_start = 1'b1;
            if (n == 900)
            begin
                // Pause the sender until every outstanding count is back.
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_counts.size() != 0)
                    @(posedge clk);
            end
            no_idle = (n >= 1100 && n < 1400);

            // Flow 0 is the heavy hitter. Some beats are noise with fresh keys
            // and columns, and a few carry the all-zero key.
            pick  = $urandom_range(0, 99);
            flow  = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(0, FLOWS - 1);
            b.cmd = ($urandom_range(0, 99) < 35) ? CMD_QUERY : CMD_UPDATE;
            b.src = pool_src[flow];
            b.dst = pool_dst[flow];
            b.idx = pool_idx[flow];
            if (pick < 10)
            begin
                b.src = $urandom;
                b.dst = $urandom;
                for (int r = 0; r < IDX_CNT; r++)
                    b.idx[r] = IDX_W'($urandom_range(0, 1023));
            end
            else if (pick < 13)
            begin
                b.src = '0;
                b.dst = '0;
            end
            send_beat(b, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including the clearing
    // pass and the long hold-off.
    initial
    begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
